// ===== rtl/ilc_pkg.sv =====
// Shared types, codes and the effective-level function for the indicator level controller.
package ilc_pkg;

	localparam int NumInd    = 8;
	localparam int NumToggle = 6;
	localparam int MaskW     = 9;
	localparam int AddrW     = 3;
	localparam int DataW     = 32;

	typedef logic [1:0] level_t;
	typedef level_t [NumInd-1:0] levels_t;
	typedef logic [NumInd-1:0] pins_t;
	typedef logic [MaskW-1:0] mask_t;
	typedef logic [2:0] ind_t;
	typedef logic [1:0] status_t;

	// Level codes.
	localparam level_t LVL_OFF  = 2'd0;
	localparam level_t LVL_ON   = 2'd1;
	localparam level_t LVL_SLOW = 2'd2;
	localparam level_t LVL_FAST = 2'd3;

	// Result status codes.
	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_DISABLED    = 2'd1;
	localparam status_t ST_OVERWRITTEN = 2'd2;
	localparam status_t ST_ERROR       = 2'd3;

	// Command codes.
	localparam logic CMD_SET    = 1'b0;
	localparam logic CMD_TOGGLE = 1'b1;

	// Indicator numbers.
	localparam ind_t IND_INFO   = 3'd2;
	localparam ind_t IND_AV1    = 3'd3;
	localparam ind_t IND_AV3    = 3'd5;
	localparam ind_t IND_BUZZER = 3'd6;
	localparam ind_t IND_SD     = 3'd7;

	// Bit positions in the enable mask.
	localparam int EN_GLOBAL   = 0;
	localparam int EN_STATUS   = 1;
	localparam int EN_BUZ_SET  = 2;
	localparam int EN_BUZ_OUT  = 3;
	localparam int EN_SD       = 4;
	localparam int EN_AV_GROUP = 5;
	localparam int EN_AV1      = 6;
	localparam int EN_AV2      = 7;
	localparam int EN_AV3      = 8;

	// Register index of the enable mask.
	localparam logic REG_ENABLE_MASK = 1'b0;

	// Outcome of one item, handed from the evaluation logic to the top level.
	typedef struct packed {
		levels_t levels;
		pins_t   pins;
		status_t status;
	} eval_t;

	// Level an indicator shows once the enable bits are applied.
	function automatic level_t eff_level(input ind_t idx, input mask_t mask,
			input levels_t lv);
		logic on;
		begin
			on = 1'b0;
			case (idx)
				3'd0, 3'd1, 3'd2: on = mask[EN_STATUS];
				3'd3: on = mask[EN_AV_GROUP] & mask[EN_AV1];
				3'd4: on = mask[EN_AV_GROUP] & mask[EN_AV2];
				3'd5: on = mask[EN_AV_GROUP] & mask[EN_AV3];
				3'd6: on = mask[EN_BUZ_OUT];
				3'd7: on = mask[EN_SD];
				default: on = 1'b0;
			endcase
			eff_level = (mask[EN_GLOBAL] && on) ? lv[idx] : LVL_OFF;
		end
	endfunction

endpackage

// ===== rtl/ilc_eval.sv =====
// Single-pass evaluation of one set or toggle item against the stored levels and pins.
module ilc_eval import ilc_pkg::*; (
	input  logic    cmd,
	input  ind_t    indicator,
	input  level_t  level,
	input  mask_t   enable_mask,
	input  levels_t levels,
	input  pins_t   pins,
	output eval_t   result
);

	logic    kind_en;
	logic    refused;
	level_t  store_lvl;
	levels_t set_levels;
	pins_t   set_pins;
	pins_t   tog_pins;
	status_t set_status;
	level_t  e;

	// Enable that gates a set for the indicator's kind.
	always_comb begin
		if (indicator <= IND_INFO)
			kind_en = enable_mask[EN_STATUS];
		else if (indicator <= IND_AV3)
			kind_en = enable_mask[EN_AV_GROUP];
		else if (indicator == IND_BUZZER)
			kind_en = enable_mask[EN_BUZ_SET];
		else
			kind_en = enable_mask[EN_SD];
	end

	assign refused = !enable_mask[EN_GLOBAL] || !kind_en
		|| (eff_level(indicator, enable_mask, levels) == level);

	// Set path: exclusivity of the status lamps, forced rewrites, then static pin drive.
	always_comb begin
		set_levels = levels;
		set_status = ST_OK;
		store_lvl  = level;
		if (indicator <= IND_INFO && level != LVL_OFF) begin
			set_levels[0] = LVL_OFF;
			set_levels[1] = LVL_OFF;
			set_levels[2] = LVL_OFF;
			set_status    = ST_OVERWRITTEN;
		end
		if (indicator == IND_BUZZER && level == LVL_FAST) begin
			store_lvl  = LVL_SLOW;
			set_status = ST_OVERWRITTEN;
		end else if (indicator == IND_SD && (level == LVL_SLOW || level == LVL_FAST)) begin
			store_lvl  = LVL_ON;
			set_status = ST_OVERWRITTEN;
		end
		set_levels[indicator] = store_lvl;
		set_pins = pins;
		for (int i = 0; i < NumInd; i++) begin
			e = eff_level(ind_t'(i), enable_mask, set_levels);
			if (e == LVL_ON)
				set_pins[i] = 1'b1;
			else if (e == LVL_OFF)
				set_pins[i] = 1'b0;
		end
	end

	// Toggle path: flip the first six pins whose effective level matches the rate.
	always_comb begin
		tog_pins = pins;
		for (int i = 0; i < NumToggle; i++) begin
			if (eff_level(ind_t'(i), enable_mask, levels) == level)
				tog_pins[i] = ~pins[i];
		end
	end

	// Select the outcome.
	always_comb begin
		result.levels = levels;
		result.pins   = pins;
		result.status = ST_OK;
		if (cmd == CMD_SET) begin
			if (refused) begin
				result.status = ST_DISABLED;
			end else begin
				result.levels = set_levels;
				result.pins   = set_pins;
				result.status = set_status;
			end
		end else if (level == LVL_OFF || level == LVL_ON) begin
			result.status = ST_ERROR;
		end else begin
			result.pins = tog_pins;
		end
	end

endmodule

// ===== rtl/indicator_level_controller_top.sv =====
// Top level of the indicator level controller: input register, evaluation, result register.
// The controller takes one item per clock cycle unless in_stall is high. Each accepted item
// is first captured in an input register, then evaluated against the stored levels and pin
// register in one pass of combinational logic and written to the result register, where it
// waits while out_stall is high. The stored levels and pins are updated in the same cycle the
// result register is loaded, so back-to-back items see each other's effects. The enable mask
// lives at byte address 0 of the APB port; write it only while no item is in flight.
module indicator_level_controller_top import ilc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cmd,
	input  ind_t             indicator,
	input  level_t           level,
	// Result channel
	output logic             out_valid,
	input  logic             out_stall,
	output status_t          status,
	output pins_t            pin_states,
	// Configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	logic    valid_s1;
	logic    cmd_s1;
	ind_t    ind_s1;
	level_t  level_s1;
	logic    advance;
	mask_t   enable_mask_q;
	levels_t levels_q;
	pins_t   pins_q;
	logic    out_valid_q;
	status_t status_q;
	pins_t   out_pins_q;
	eval_t   eval;

	assign pready = 1'b1;

	// Configuration register write and readback.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[AddrW-1] == REG_ENABLE_MASK) begin
			enable_mask_q <= pwdata[MaskW-1:0];
		end
	end

	assign prdata = (paddr[AddrW-1] == REG_ENABLE_MASK)
		? {{(DataW-MaskW){1'b0}}, enable_mask_q} : '0;

	// The evaluated item moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1   <= cmd;
			ind_s1   <= indicator;
			level_s1 <= level;
		end
	end

	ilc_eval u_eval (
		.cmd         (cmd_s1),
		.indicator   (ind_s1),
		.level       (level_s1),
		.enable_mask (enable_mask_q),
		.levels      (levels_q),
		.pins        (pins_q),
		.result      (eval)
	);

	// Indicator state: stored levels and the pin register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
			pins_q   <= '0;
		end else if (advance) begin
			levels_q <= eval.levels;
			pins_q   <= eval.pins;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= eval.status;
			out_pins_q <= eval.pins;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign pin_states = out_pins_q;

endmodule

// ===== verif/indicator_level_checker.sv =====
// Checker for the indicator level controller: predicts each result and compares it.
module indicator_level_checker import ilc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             cmd,
	input  ind_t             indicator,
	input  level_t           level,
	input  logic             out_valid,
	input  logic             out_stall,
	input  status_t          status,
	input  pins_t            pin_states,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic             pready,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output int               n_fail,
	output int               n_pending,
	output int               n_ok,
	output int               n_refused,
	output int               n_rewritten,
	output int               n_error
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [AddrW-1:0] MASK_ADDR = AddrW'(4 * REG_ENABLE_MASK);

	typedef struct packed {
		status_t status;
		pins_t   pins;
	} lamp_result_t;

	// Shadow copy of the controller state.
	mask_t  enables;
	level_t lamp_level [NumInd];
	pins_t  pin_reg;

	// Results still owed by the controller, oldest first.
	lamp_result_t owed_results [$];
	lamp_result_t oldest;
	lamp_result_t fresh;
	status_t      st;
	int           k;

	// Level an indicator shows once its enable bits are applied.
	function automatic level_t shown_level(input int idx);
		logic gate;
		begin
			if (idx <= IND_INFO)
				gate = enables[EN_STATUS];
			else if (idx <= IND_AV3)
				gate = enables[EN_AV_GROUP] & enables[EN_AV1 + idx - IND_AV1];
			else if (idx == IND_BUZZER)
				gate = enables[EN_BUZ_OUT];
			else
				gate = enables[EN_SD];
			return (enables[EN_GLOBAL] && gate) ? lamp_level[idx] : LVL_OFF;
		end
	endfunction

	// Set command: refusal checks, forced rewrites, then drive the steady pins.
	function automatic status_t apply_set(input int idx, input level_t want);
		level_t  lv;
		status_t res;
		int      j;
		begin
			lv = want;
			res = ST_OK;
			if (!enables[EN_GLOBAL] || shown_level(idx) == lv)
				return ST_DISABLED;
			if (idx <= IND_INFO && !enables[EN_STATUS])
				return ST_DISABLED;
			if (idx == IND_BUZZER && !enables[EN_BUZ_SET])
				return ST_DISABLED;
			if (idx == IND_SD && !enables[EN_SD])
				return ST_DISABLED;
			if (idx >= IND_AV1 && idx <= IND_AV3 && !enables[EN_AV_GROUP])
				return ST_DISABLED;
			// Only one status lamp may be lit at a time.
			if (idx <= IND_INFO && lv != LVL_OFF) begin
				for (j = 0; j <= IND_INFO; j++)
					lamp_level[j] = LVL_OFF;
				res = ST_OVERWRITTEN;
			end
			// The buzzer cannot blink fast and the SD lamp cannot blink at all.
			if (idx == IND_BUZZER && lv == LVL_FAST) begin
				lv = LVL_SLOW;
				res = ST_OVERWRITTEN;
			end else if (idx == IND_SD && (lv == LVL_SLOW || lv == LVL_FAST)) begin
				lv = LVL_ON;
				res = ST_OVERWRITTEN;
			end
			lamp_level[idx] = lv;
			for (j = 0; j < NumInd; j++) begin
				if (shown_level(j) == LVL_ON)
					pin_reg[j] = 1'b1;
				else if (shown_level(j) == LVL_OFF)
					pin_reg[j] = 1'b0;
			end
			return res;
		end
	endfunction

	// Toggle command: flip the pins of the lower lamps blinking at the given rate; a steady rate is an error.
	function automatic status_t apply_toggle(input level_t rate);
		int j;
		begin
			if (rate == LVL_OFF || rate == LVL_ON)
				return ST_ERROR;
			for (j = 0; j < NumToggle; j++) begin
				if (shown_level(j) == rate)
					pin_reg[j] = ~pin_reg[j];
			end
			return ST_OK;
		end
	endfunction

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables = '0;
			for (k = 0; k < NumInd; k++)
				lamp_level[k] = LVL_OFF;
			pin_reg = '0;
			owed_results.delete();
			n_fail = 0;
			n_pending = 0;
			n_ok = 0;
			n_refused = 0;
			n_rewritten = 0;
			n_error = 0;
		end else begin
			// Compare a delivered result with the oldest one owed.
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					if (n_fail < 10)
						$display("%0t: result with no item pending: status %0d pins %h",
							$realtime, status, pin_states);
					n_fail++;
				end else begin
					oldest = owed_results.pop_front();
					if (status !== oldest.status) begin
						if (n_fail < 10)
							$display("%0t: status mismatch: expected %0d, got %0d",
								$realtime, oldest.status, status);
						n_fail++;
					end
					if (pin_states !== oldest.pins) begin
						if (n_fail < 10)
							$display("%0t: pin_states mismatch: expected %h, got %h",
								$realtime, oldest.pins, pin_states);
						n_fail++;
					end
				end
			end

			// Predict the result of an accepted item.
			if (in_valid && !in_stall) begin
				if (cmd == CMD_SET)
					st = apply_set(indicator, level);
				else
					st = apply_toggle(level);
				case (st)
					ST_OK:          n_ok++;
					ST_DISABLED:    n_refused++;
					ST_OVERWRITTEN: n_rewritten++;
					default:        n_error++;
				endcase
				fresh.status = st;
				fresh.pins = pin_reg;
				owed_results.push_back(fresh);
			end

			// Follow writes of the enable mask.
			if (psel && penable && pwrite && pready && paddr == MASK_ADDR)
				enables = pwdata[MaskW-1:0];

			n_pending = owed_results.size();
		end
	end

endmodule

// ===== verif/indicator_level_controller_top_tb.sv =====
// Testbench top for the indicator level controller: stimulus, idling and the verdict.
module indicator_level_controller_top_tb import ilc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [AddrW-1:0] MASK_ADDR = AddrW'(4 * REG_ENABLE_MASK);
	localparam ind_t IND_ERROR = 3'd0;
	localparam ind_t IND_WARN  = 3'd1;
	localparam ind_t IND_AV2   = 3'd4;
	localparam int   NumPhases = 12;
	localparam int   PhaseLen  = 110;
	localparam int   HangLimit = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             cmd = CMD_SET;
	ind_t             indicator = '0;
	level_t           level = LVL_OFF;
	logic             out_valid;
	logic             out_stall = 1'b0;
	status_t          status;
	pins_t            pin_states;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	int n_fail, n_pending, n_ok, n_refused, n_rewritten, n_error;
	int n_sent = 0;
	int n_settings = 0;
	int quiet_cycles = 0;
	bit bursty = 1'b0;

	always #5 clk = ~clk;

	indicator_level_controller_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.indicator  (indicator),
		.level      (level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.pin_states (pin_states),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	indicator_level_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.indicator   (indicator),
		.level       (level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.pin_states  (pin_states),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.n_fail      (n_fail),
		.n_pending   (n_pending),
		.n_ok        (n_ok),
		.n_refused   (n_refused),
		.n_rewritten (n_rewritten),
		.n_error     (n_error)
	);

	// Present one item and hold it until the controller takes it.
	task automatic push_item(input logic c, input ind_t ind, input level_t lv);
		in_valid <= 1'b1;
		cmd <= c;
		indicator <= ind;
		level <= lv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// Sometimes drop valid for a random burst before the next item.
	task automatic maybe_gap();
		if (bursty && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	// Wait for every owed result, then write the enable mask over the register port.
	task automatic write_mask(input mask_t value);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (n_pending != 0);
		repeat (3)
			@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MASK_ADDR;
		pwdata <= DataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_settings++;
	endtask

	// Random stalls on the result side in bursts while idling is on.
	initial begin
		forever begin
			@(posedge clk);
			if (bursty && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13))
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// End the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HangLimit) begin
			$display("timeout: no handshake for %0d cycles", HangLimit);
			$display("indicator_level_controller_top regression: fail");
			$finish;
		end
	end

	// Main stimulus: directed items, then random phases under varied enable masks.
	initial begin
		mask_t  m;
		logic   c;
		int     ph;
		int     n;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset mask everything is refused or left alone.
		push_item(CMD_SET, IND_ERROR, LVL_ON);
		push_item(CMD_TOGGLE, IND_ERROR, LVL_SLOW);

		// Everything enabled: each indicator, each level and each forced rewrite.
		write_mask(9'h1FF);
		push_item(CMD_SET, IND_ERROR, LVL_ON);
		push_item(CMD_SET, IND_ERROR, LVL_ON);
		push_item(CMD_SET, IND_WARN, LVL_SLOW);
		push_item(CMD_SET, IND_INFO, LVL_FAST);
		push_item(CMD_SET, IND_INFO, LVL_OFF);
		push_item(CMD_SET, IND_AV1, LVL_ON);
		push_item(CMD_SET, IND_AV2, LVL_SLOW);
		push_item(CMD_SET, IND_AV3, LVL_FAST);
		push_item(CMD_SET, IND_BUZZER, LVL_FAST);
		push_item(CMD_SET, IND_BUZZER, LVL_ON);
		push_item(CMD_SET, IND_SD, LVL_SLOW);
		push_item(CMD_SET, IND_SD, LVL_OFF);
		push_item(CMD_SET, IND_SD, LVL_FAST);
		push_item(CMD_TOGGLE, IND_SD, LVL_OFF);
		push_item(CMD_TOGGLE, IND_BUZZER, LVL_ON);
		push_item(CMD_TOGGLE, IND_ERROR, LVL_SLOW);
		push_item(CMD_TOGGLE, IND_AV3, LVL_FAST);
		push_item(CMD_SET, IND_WARN, LVL_FAST);
		push_item(CMD_TOGGLE, IND_INFO, LVL_FAST);
		push_item(CMD_SET, IND_WARN, LVL_OFF);
		push_item(CMD_SET, IND_AV1, LVL_OFF);

		// Random phases; the first few masks are the extremes, the last phase runs flat out.
		for (ph = 0; ph < NumPhases; ph++) begin
			case (ph)
				0: m = 9'h1FF;
				1: m = 9'h000;
				2: m = 9'h001;
				3: m = 9'h1FE;
				7: m = mask_t'($urandom_range(0, 511));
				default: m = mask_t'($urandom_range(0, 511)) | 9'h001;
			endcase
			bursty = 1'b0;
			write_mask(m);
			bursty = (ph != NumPhases - 1) && ($urandom_range(0, 3) != 0);
			for (n = 0; n < PhaseLen; n++) begin
				maybe_gap();
				c = ($urandom_range(0, 9) < 3) ? CMD_TOGGLE : CMD_SET;
				push_item(c, ind_t'($urandom_range(0, 7)), level_t'($urandom_range(0, 3)));
			end
		end

		// Drain the last results and give the controller a few more cycles.
		bursty = 1'b0;
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (n_pending != 0);
		repeat (5)
			@(posedge clk);

		$display("Sent %0d items under %0d enable mask settings, with and without idling.",
			n_sent, n_settings);
		$display("Results by status: ok %0d, refused %0d, rewritten %0d, error %0d.",
			n_ok, n_refused, n_rewritten, n_error);
		if (n_fail == 0 && n_pending == 0)
			$display("indicator_level_controller_top regression: pass");
		else
			$display("indicator_level_controller_top regression: fail");
		$finish;
	end

endmodule
